>>> sv/loop_task_timing_monitor_top_macros.svh
// Assertion macros for the loop and task timing monitor.
// Used by the checker module; relies on clk and rst_n in the including scope.
`ifndef LOOP_TASK_TIMING_MONITOR_TOP_MACROS_SVH
`define LOOP_TASK_TIMING_MONITOR_TOP_MACROS_SVH

// Property checked only outside reset.
`define LTM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define LTM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/ltm_pkg.sv
// Package for the loop and task timing monitor: sizes, operation codes
// and the stage register type. No dependencies.
`default_nettype none

package ltm_pkg;

  // Number of task slots, and the bits needed to address one.
  localparam int TASK_COUNT = 8;
  localparam int IDX_W      = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam int TICK_W     = 32;

  localparam logic [TICK_W-1:0] WARN_THR_RESET = TICK_W'(50);

  // Operation codes of an event word.
  localparam logic [1:0] OP_LOOP_BEGIN = 2'd0;
  localparam logic [1:0] OP_TASK_BEGIN = 2'd1;
  localparam logic [1:0] OP_TASK_END   = 2'd2;

  // Event held while its memory reads complete, with forwarded write data.
  typedef struct packed {
    logic [1:0]        op;
    logic [IDX_W-1:0]  idx;
    logic              ok;
    logic [TICK_W-1:0] now;
    logic              st_fwd;
    logic [TICK_W-1:0] st_fwd_data;
    logic              mx_fwd;
    logic [TICK_W-1:0] mx_fwd_data;
  } s1_t;

endpackage

`default_nettype wire

>>> sv/ltm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module ltm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> sv/loop_task_timing_monitor_top.sv
// Top level of the loop and task timing monitor.
// Depends on ltm_pkg and ltm_ram.
`default_nettype none

// Accepts one event word per clock cycle while the output side is not stalled, and
// returns one snapshot word per event. The event waits in a stage register for
// the registered read of the task start and task maximum memories, then the
// read-modify-write completes and the snapshot is registered. A write that lands
// in the same cycle as the next event's read is forwarded to it. Task entries carry
// valid bits cleared at reset, so the block is ready in the first cycle after reset
// with no clearing pass.
module loop_task_timing_monitor_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_operation,
  input  wire logic [7:0]  in_task_index,
  input  wire logic [31:0] in_now_tick,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_loop_count,
  output logic [31:0]      out_last_loop_period,
  output logic [31:0]      out_max_loop_period,
  output logic [31:0]      out_overrun_count,
  output logic [31:0]      out_task_max_elapsed,
  output logic             out_task_invalid
);

  localparam int IW = ltm_pkg::IDX_W;
  localparam int TW = ltm_pkg::TICK_W;

  // Handshake and stage control.
  logic          in_acc;
  logic          s1_adv;
  logic          s1_valid_r;
  ltm_pkg::s1_t  s1_r;
  logic          out_valid_r;
  logic          in_ok;
  logic [IW-1:0] in_idx;

  // Loop state and threshold.
  logic [TW-1:0] warn_thr_r;
  logic [TW-1:0] prev_start_r, prev_start_nxt;
  logic [TW-1:0] loop_cnt_r, loop_cnt_nxt;
  logic [TW-1:0] last_period_r, last_period_nxt;
  logic [TW-1:0] max_period_r, max_period_nxt;
  logic [TW-1:0] overrun_cnt_r, overrun_cnt_nxt;
  logic [TW-1:0] period;

  // Task memories and their valid bits.
  logic [ltm_pkg::TASK_COUNT-1:0] st_vld_r;
  logic [ltm_pkg::TASK_COUNT-1:0] mx_vld_r;
  logic [TW-1:0] st_rd, mx_rd;
  logic [TW-1:0] st_cur, mx_cur, mx_new, elapsed;
  logic          st_we, mx_we;

  // Result registers.
  logic [TW-1:0] out_loop_count_r, out_last_r, out_max_r, out_overrun_r, out_task_max_r;
  logic          out_invalid_r;

  assign in_ok  = {1'b0, in_task_index} < 9'(ltm_pkg::TASK_COUNT);
  assign in_idx = in_task_index[IW-1:0];

  // A stage moves on when the result register is free or being emptied.
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warn_thr_r <= ltm_pkg::WARN_THR_RESET;
    end else if (cfg_wr_en) begin
      warn_thr_r <= cfg_wr_data;
    end
  end

  // Task start ticks.
  ltm_ram #(.WIDTH(TW), .DEPTH(ltm_pkg::TASK_COUNT)) u_start_ram (
    .clk     (clk),
    .wr_en   (st_we),
    .wr_addr (s1_r.idx),
    .wr_data (s1_r.now),
    .rd_en   (in_acc),
    .rd_addr (in_idx),
    .rd_data (st_rd)
  );

  // Task maximum elapsed times.
  ltm_ram #(.WIDTH(TW), .DEPTH(ltm_pkg::TASK_COUNT)) u_max_ram (
    .clk     (clk),
    .wr_en   (mx_we),
    .wr_addr (s1_r.idx),
    .wr_data (mx_new),
    .rd_en   (in_acc),
    .rd_addr (in_idx),
    .rd_data (mx_rd)
  );

  // Current entry values: forwarded write, else stored word, else reset value.
  always_comb begin
    if (s1_r.st_fwd) begin
      st_cur = s1_r.st_fwd_data;
    end else if (s1_r.ok && st_vld_r[s1_r.idx]) begin
      st_cur = st_rd;
    end else begin
      st_cur = '0;
    end
    if (s1_r.mx_fwd) begin
      mx_cur = s1_r.mx_fwd_data;
    end else if (s1_r.ok && mx_vld_r[s1_r.idx]) begin
      mx_cur = mx_rd;
    end else begin
      mx_cur = '0;
    end
  end

  // Event decode and state update.
  always_comb begin
    prev_start_nxt  = prev_start_r;
    loop_cnt_nxt    = loop_cnt_r;
    last_period_nxt = last_period_r;
    max_period_nxt  = max_period_r;
    overrun_cnt_nxt = overrun_cnt_r;
    period          = s1_r.now - prev_start_r;
    elapsed         = s1_r.now - st_cur;
    mx_new          = mx_cur;
    st_we           = 1'b0;
    mx_we           = 1'b0;
    unique case (s1_r.op)
      ltm_pkg::OP_LOOP_BEGIN: begin
        if (prev_start_r != '0) begin
          last_period_nxt = period;
          if (period > max_period_r) begin
            max_period_nxt = period;
          end
          if (period > warn_thr_r) begin
            overrun_cnt_nxt = overrun_cnt_r + TW'(1);
          end
        end
        prev_start_nxt = s1_r.now;
        loop_cnt_nxt   = loop_cnt_r + TW'(1);
      end
      ltm_pkg::OP_TASK_BEGIN: begin
        st_we = s1_adv && s1_r.ok;
      end
      ltm_pkg::OP_TASK_END: begin
        if (s1_r.ok && (st_cur != '0) && (elapsed > mx_cur)) begin
          mx_new = elapsed;
          mx_we  = s1_adv;
        end
      end
      default: begin
      end
    endcase
  end

  // Stage register: the event waiting for its memory reads.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r.op          <= in_operation;
      s1_r.idx         <= in_idx;
      s1_r.ok          <= in_ok;
      s1_r.now         <= in_now_tick;
      s1_r.st_fwd      <= st_we && in_ok && (in_idx == s1_r.idx);
      s1_r.st_fwd_data <= s1_r.now;
      s1_r.mx_fwd      <= mx_we && in_ok && (in_idx == s1_r.idx);
      s1_r.mx_fwd_data <= mx_new;
    end
  end

  // Loop state and entry valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_start_r  <= '0;
      loop_cnt_r    <= '0;
      last_period_r <= '0;
      max_period_r  <= '0;
      overrun_cnt_r <= '0;
      st_vld_r      <= '0;
      mx_vld_r      <= '0;
    end else if (s1_adv) begin
      prev_start_r  <= prev_start_nxt;
      loop_cnt_r    <= loop_cnt_nxt;
      last_period_r <= last_period_nxt;
      max_period_r  <= max_period_nxt;
      overrun_cnt_r <= overrun_cnt_nxt;
      if (st_we) begin
        st_vld_r[s1_r.idx] <= 1'b1;
      end
      if (mx_we) begin
        mx_vld_r[s1_r.idx] <= 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_loop_count_r <= loop_cnt_nxt;
      out_last_r       <= last_period_nxt;
      out_max_r        <= max_period_nxt;
      out_overrun_r    <= overrun_cnt_nxt;
      out_task_max_r   <= s1_r.ok ? mx_new : '0;
      out_invalid_r    <= !s1_r.ok && ((s1_r.op == ltm_pkg::OP_TASK_BEGIN) ||
                                       (s1_r.op == ltm_pkg::OP_TASK_END));
    end
  end

  assign out_valid            = out_valid_r;
  assign out_loop_count       = out_loop_count_r;
  assign out_last_loop_period = out_last_r;
  assign out_max_loop_period  = out_max_r;
  assign out_overrun_count    = out_overrun_r;
  assign out_task_max_elapsed = out_task_max_r;
  assign out_task_invalid     = out_invalid_r;

endmodule

`default_nettype wire

>>> sv/ltm_checker.sv
// Port-level checker for the loop and task timing monitor, bound to the top level.
// Depends on loop_task_timing_monitor_top_macros.svh.
`default_nettype none

`include "loop_task_timing_monitor_top_macros.svh"

module ltm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_loop_count,
  input wire logic [31:0] out_last_loop_period,
  input wire logic [31:0] out_max_loop_period,
  input wire logic [31:0] out_task_max_elapsed,
  input wire logic        out_task_invalid
);

  // No result word is offered straight after reset.
  `LTM_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result offered after reset")

  // An ignored task event reports no task maximum.
  `LTM_ASSERT(a_invalid_zero, out_valid && out_task_invalid |-> out_task_max_elapsed == 32'd0, "invalid task with non-zero maximum")

  // The maximum period never falls below the latest period.
  `LTM_ASSERT(a_max_ge_last, out_valid |-> out_max_loop_period >= out_last_loop_period, "maximum period below last period")

  // A stalled result word holds.
  `LTM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_loop_count) && $stable(out_task_max_elapsed), "stalled result changed")

endmodule

bind loop_task_timing_monitor_top ltm_checker u_ltm_checker (.*);

`default_nettype wire
